### design/lpbt_pkg.sv
// ============================================================================
// lpbt_pkg - shared types for the LRU page buffer tracker
// Request kinds, page tag layout, result layout and rank update commands.
// ============================================================================
`default_nettype none

package lpbt_pkg;

  localparam int FileW  = 8;
  localparam int PageW  = 24;
  localparam int FrameW = 4;

  typedef enum logic [2:0] {
    KIND_GET         = 3'd0,
    KIND_MARK_DIRTY  = 3'd1,
    KIND_DISCARD     = 3'd2,
    KIND_FLUSH_PAGE  = 3'd3,
    KIND_FLUSH_FILE  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    RK_HOLD    = 2'd0,
    RK_PROMOTE = 2'd1,
    RK_INSERT  = 2'd2,
    RK_REMOVE  = 2'd3
  } rank_op_e;

  typedef struct packed {
    logic [FileW-1:0] file_id;
    logic [PageW-1:0] page_number;
  } tag_t;

  typedef struct packed {
    logic              hit;
    logic [FrameW-1:0] frame;
    logic              load_needed;
    logic              writeback;
    logic [FileW-1:0]  wb_file_id;
    logic [PageW-1:0]  wb_page_number;
    logic              status;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

### design/lpbt_tag_mem.sv
// ============================================================================
// lpbt_tag_mem - frame tag memory
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module lpbt_tag_mem
  import lpbt_pkg::*;
#(
  parameter int NUM_FRAMES = 16,
  localparam int IdxW = $clog2(NUM_FRAMES)
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire tag_t            wdata_i,
  input  wire logic            re_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output tag_t                 rdata_o
);

  tag_t mem_q [NUM_FRAMES];
  tag_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/lpbt_rank_array.sv
// ============================================================================
// lpbt_rank_array - recency ranks of all frames
// Each frame keeps its rank; one command per cycle promotes, inserts or
// removes a frame and shifts the ranks of other valid frames as needed.
// ============================================================================
`default_nettype none

module lpbt_rank_array
  import lpbt_pkg::*;
#(
  parameter int NUM_FRAMES = 16,
  localparam int IdxW = $clog2(NUM_FRAMES)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [NUM_FRAMES-1:0] valid_i,
  input  wire rank_op_e              op_i,
  input  wire logic [IdxW-1:0]       idx_i,
  input  wire logic [IdxW-1:0]       ref_i,
  output logic      [IdxW-1:0]       rank_o [NUM_FRAMES]
);

  logic [IdxW-1:0] rank_q [NUM_FRAMES];
  logic [IdxW-1:0] rank_d [NUM_FRAMES];

  always_comb begin
    logic is_tgt;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      is_tgt    = (IdxW'(i) == idx_i);
      rank_d[i] = rank_q[i];
      case (op_i)
        RK_PROMOTE: begin
          if (is_tgt) begin
            rank_d[i] = '0;
          end else if (valid_i[i] && (rank_q[i] < ref_i)) begin
            rank_d[i] = rank_q[i] + IdxW'(1);
          end
        end
        RK_INSERT: begin
          if (is_tgt) begin
            rank_d[i] = '0;
          end else if (valid_i[i]) begin
            rank_d[i] = rank_q[i] + IdxW'(1);
          end
        end
        RK_REMOVE: begin
          if (is_tgt) begin
            rank_d[i] = '0;
          end else if (valid_i[i] && (rank_q[i] > ref_i)) begin
            rank_d[i] = rank_q[i] - IdxW'(1);
          end
        end
        default: begin
          rank_d[i] = rank_q[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  assign rank_o = rank_q;

endmodule

`default_nettype wire

### design/lru_page_buffer_tracker.sv
// ============================================================================
// lru_page_buffer_tracker - LRU buffer pool bookkeeping with dirty bits
// Sequencer, scan compare unit and result register of the tracker.
// ============================================================================
// Usage: the host sends one request (kind, file_id, page_number) on the input
// channel; in_stall_o is high while a request is being worked on, so only one
// request is in flight. A get, mark_dirty, discard, flush_page or flush_file
// scans all NUM_FRAMES frames through one shared tag compare unit, one frame
// per cycle unless the scan is held, reading the tag memory one frame ahead
// of the compare. A final step then loads the final result: S_EXEC, which
// also updates the frame state, or S_FLUSH_END for a flush_file. A request
// of an unused kind skips the scan and goes straight to S_EXEC.
// A flush_file gives one result per dirty frame of the file, in frame order,
// with last set only on the final one. Each result is held back until the
// next one is found, so that last can be known; if no frame matches, a
// single empty result with last is given.
// When the receiver stalls, the result register holds its result; the final
// result waits in the sequencer, and the scan waits only when a flush_file
// has a further result to hand over.
// After reset all frames are empty and clean; the tag memory needs no
// clearing pass, since tags are only compared for valid frames.
// ============================================================================
`default_nettype none

module lru_page_buffer_tracker
  import lpbt_pkg::*;
#(
  parameter int NUM_FRAMES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Request channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        kind_i,
  input  wire logic [FileW-1:0]  file_id_i,
  input  wire logic [PageW-1:0]  page_number_i,
  // Result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   hit_o,
  output logic [FrameW-1:0]      frame_o,
  output logic                   load_needed_o,
  output logic                   writeback_o,
  output logic [FileW-1:0]       wb_file_id_o,
  output logic [PageW-1:0]       wb_page_number_o,
  output logic                   status_o,
  output logic                   last_o
);

  localparam int IdxW = $clog2(NUM_FRAMES);
  localparam int CntW = $clog2(NUM_FRAMES + 1);
  localparam logic [CntW-1:0] ScanEnd    = CntW'(NUM_FRAMES);
  localparam logic [IdxW-1:0] OldestRank = IdxW'(NUM_FRAMES - 1);

  typedef enum logic [3:0] {
    S_IDLE      = 4'b0001,
    S_SCAN      = 4'b0010,
    S_EXEC      = 4'b0100,
    S_FLUSH_END = 4'b1000
  } state_e;

  // The frame field carries the low bits of the frame index.
  function automatic logic [FrameW-1:0] frame_of(input logic [IdxW-1:0] idx);
    logic [IdxW+FrameW-1:0] ext;
    ext = {{FrameW{1'b0}}, idx};
    return ext[FrameW-1:0];
  endfunction

  state_e state_q, state_d;

  // Request being worked on.
  kind_e            kind_q;
  logic [FileW-1:0] fid_q;
  logic [PageW-1:0] pno_q;

  // Per-frame status bits.
  logic [NUM_FRAMES-1:0] valid_q, valid_d;
  logic [NUM_FRAMES-1:0] dirty_q, dirty_d;

  // Scan pipeline: read address stage and compare stage.
  logic [CntW-1:0] rd_idx_q;
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;
  tag_t            tag_rd;

  // What the scan found.
  logic            match_q;
  logic [IdxW-1:0] match_idx_q;
  logic [IdxW-1:0] match_rank_q;
  logic            free_q;
  logic [IdxW-1:0] free_idx_q;
  logic [IdxW-1:0] vic_idx_q;
  tag_t            vic_tag_q;

  // Flush_file result held back until the next one or the end of the scan.
  logic             pend_q;
  logic [IdxW-1:0]  pend_idx_q;
  logic [PageW-1:0] pend_page_q;

  // Result register.
  logic out_vld_q;
  res_t out_q;
  res_t out_nx;
  logic out_ld;
  logic out_free;

  // Rank array command.
  logic [IdxW-1:0] rank [NUM_FRAMES];
  rank_op_e        rk_op;
  logic [IdxW-1:0] rk_idx;
  logic [IdxW-1:0] rk_ref;

  // Tag memory ports.
  logic            mem_we;
  logic            mem_re;
  logic [IdxW-1:0] ins_idx;
  tag_t            mem_wdata;

  // Compare unit.
  logic [IdxW-1:0] cmp_rank;
  logic            cmp_valid;
  logic            file_eq;
  logic            tag_hit;
  logic            ff_hit;
  logic            scan_hold;
  logic            scan_adv;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  assign cmp_rank  = rank[cmp_idx_q];
  assign cmp_valid = cmp_vld_q && valid_q[cmp_idx_q];
  assign file_eq   = (tag_rd.file_id == fid_q);
  assign tag_hit   = cmp_valid && file_eq && (tag_rd.page_number == pno_q);
  assign ff_hit    = cmp_valid && (kind_q == KIND_FLUSH_FILE) && dirty_q[cmp_idx_q] && file_eq;

  // A flush_file hit can only move on once the held result has been handed over.
  assign scan_hold = ff_hit && pend_q && !out_free;
  assign scan_adv  = (state_q == S_SCAN) && !scan_hold;
  assign mem_re    = scan_adv && (rd_idx_q != ScanEnd);

  // A miss takes the lowest free frame, or else the least recently used one.
  assign ins_idx   = free_q ? free_idx_q : vic_idx_q;
  assign mem_wdata = '{file_id: fid_q, page_number: pno_q};

  lpbt_tag_mem #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_tag_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (ins_idx),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (tag_rd)
  );

  lpbt_rank_array #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_rank_array (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_q),
    .op_i    (rk_op),
    .idx_i   (rk_idx),
    .ref_i   (rk_ref),
    .rank_o  (rank)
  );

  // Sequencer and result selection.
  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    dirty_d = dirty_q;
    out_ld  = 1'b0;
    out_nx  = '0;
    rk_op   = RK_HOLD;
    rk_idx  = match_idx_q;
    rk_ref  = match_rank_q;
    mem_we  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (kind_i <= KIND_FLUSH_FILE) ? S_SCAN : S_EXEC;
        end
      end

      S_SCAN: begin
        if (ff_hit && !scan_hold) begin
          dirty_d[cmp_idx_q] = 1'b0;
          if (pend_q) begin
            out_ld                = 1'b1;
            out_nx.hit            = 1'b1;
            out_nx.frame          = frame_of(pend_idx_q);
            out_nx.writeback      = 1'b1;
            out_nx.wb_file_id     = fid_q;
            out_nx.wb_page_number = pend_page_q;
          end
        end
        if ((rd_idx_q == ScanEnd) && !cmp_vld_q) begin
          state_d = (kind_q == KIND_FLUSH_FILE) ? S_FLUSH_END : S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_ld      = 1'b1;
          out_nx.last = 1'b1;
          state_d     = S_IDLE;
          case (kind_q)
            KIND_GET: begin
              if (match_q) begin
                out_nx.hit   = 1'b1;
                out_nx.frame = frame_of(match_idx_q);
                rk_op        = RK_PROMOTE;
              end else begin
                out_nx.load_needed = 1'b1;
                out_nx.frame       = frame_of(ins_idx);
                rk_op              = RK_INSERT;
                rk_idx             = ins_idx;
                valid_d[ins_idx]   = 1'b1;
                dirty_d[ins_idx]   = 1'b0;
                mem_we             = 1'b1;
                // A full pool evicts its oldest frame, written back if dirty.
                if (!free_q && dirty_q[vic_idx_q]) begin
                  out_nx.writeback      = 1'b1;
                  out_nx.wb_file_id     = vic_tag_q.file_id;
                  out_nx.wb_page_number = vic_tag_q.page_number;
                end
              end
            end
            KIND_MARK_DIRTY: begin
              if (match_q) begin
                out_nx.hit           = 1'b1;
                out_nx.frame         = frame_of(match_idx_q);
                dirty_d[match_idx_q] = 1'b1;
              end else begin
                out_nx.status = 1'b1;
              end
            end
            KIND_DISCARD: begin
              if (match_q) begin
                out_nx.hit           = 1'b1;
                out_nx.frame         = frame_of(match_idx_q);
                valid_d[match_idx_q] = 1'b0;
                dirty_d[match_idx_q] = 1'b0;
                rk_op                = RK_REMOVE;
              end
            end
            KIND_FLUSH_PAGE: begin
              if (match_q) begin
                out_nx.hit   = 1'b1;
                out_nx.frame = frame_of(match_idx_q);
                if (dirty_q[match_idx_q]) begin
                  out_nx.writeback      = 1'b1;
                  out_nx.wb_file_id     = fid_q;
                  out_nx.wb_page_number = pno_q;
                  dirty_d[match_idx_q]  = 1'b0;
                end
              end
            end
            default: begin
              out_nx.last = 1'b1;
            end
          endcase
        end
      end

      S_FLUSH_END: begin
        if (out_free) begin
          out_ld      = 1'b1;
          out_nx.last = 1'b1;
          state_d     = S_IDLE;
          if (pend_q) begin
            out_nx.hit            = 1'b1;
            out_nx.frame          = frame_of(pend_idx_q);
            out_nx.writeback      = 1'b1;
            out_nx.wb_file_id     = fid_q;
            out_nx.wb_page_number = pend_page_q;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      kind_q    <= KIND_GET;
      valid_q   <= '0;
      dirty_q   <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      dirty_q <= dirty_d;

      if ((state_q == S_IDLE) && in_valid_i) begin
        kind_q    <= kind_e'(kind_i);
        rd_idx_q  <= '0;
        cmp_vld_q <= 1'b0;
        match_q   <= 1'b0;
        free_q    <= 1'b0;
        pend_q    <= 1'b0;
      end

      if (scan_adv) begin
        if (rd_idx_q != ScanEnd) begin
          rd_idx_q  <= rd_idx_q + CntW'(1);
          cmp_vld_q <= 1'b1;
        end else begin
          cmp_vld_q <= 1'b0;
        end
        if (tag_hit) begin
          match_q <= 1'b1;
        end
        if (cmp_vld_q && !valid_q[cmp_idx_q]) begin
          free_q <= 1'b1;
        end
        if (ff_hit) begin
          pend_q <= 1'b1;
        end
      end

      if ((state_q == S_FLUSH_END) && out_free) begin
        pend_q <= 1'b0;
      end

      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      fid_q <= file_id_i;
      pno_q <= page_number_i;
    end

    if (scan_adv) begin
      cmp_idx_q <= rd_idx_q[IdxW-1:0];
      if (tag_hit) begin
        match_idx_q  <= cmp_idx_q;
        match_rank_q <= cmp_rank;
      end
      // Keep only the lowest free frame.
      if (cmp_vld_q && !valid_q[cmp_idx_q] && !free_q) begin
        free_idx_q <= cmp_idx_q;
      end
      // Ranks of valid frames form a permutation, so the oldest holds the top rank.
      if (cmp_valid && (cmp_rank == OldestRank)) begin
        vic_idx_q <= cmp_idx_q;
        vic_tag_q <= tag_rd;
      end
      if (ff_hit) begin
        pend_idx_q  <= cmp_idx_q;
        pend_page_q <= tag_rd.page_number;
      end
    end

    if (out_ld) begin
      out_q <= out_nx;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign hit_o            = out_q.hit;
  assign frame_o          = out_q.frame;
  assign load_needed_o    = out_q.load_needed;
  assign writeback_o      = out_q.writeback;
  assign wb_file_id_o     = out_q.wb_file_id;
  assign wb_page_number_o = out_q.wb_page_number;
  assign status_o         = out_q.status;
  assign last_o           = out_q.last;

`ifndef SYNTHESIS
  // No flush_file result is left behind once the block is idle.
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_q)
    else $error("held flush result left in idle");

  // Only resident frames can be dirty.
  a_dirty_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((dirty_q & ~valid_q) == '0))
    else $error("dirty bit set on a free frame");

  // At most one frame is filled or freed per cycle.
  a_one_frame_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(valid_q ^ $past(valid_q)) <= 1))
    else $error("more than one frame changed residency");

  // Results handed over during the scan are never the final one.
  a_scan_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && out_ld) |-> !out_nx.last)
    else $error("final result given during scan");

  // A held result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |-> !out_ld)
    else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
// ============================================================================
// tb - self-checking bench for the LRU page buffer tracker
// Sends page requests in bursts against a result side that stalls, and checks
// every result against a frame pool model kept inside the bench.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpbt_pkg::*;

  localparam int NumFrames      = 16;
  localparam int ClkHalf        = 4;
  localparam int ResetCycles    = 7;
  localparam int RandomRequests = 500;
  // The tail is longer than the tracker takes for one request.
  localparam int TailCycles     = 2 * NumFrames + 8;
  localparam int FilePoolSize   = 3;
  localparam int PagePoolSize   = 10;

  // Kind codes that the package leaves unnamed. The tracker answers them with
  // an empty result and changes nothing.
  localparam logic [2:0] KindUnusedLo = 3'd5;
  localparam logic [2:0] KindUnusedHi = 3'd7;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BLOCKS
  } stall_style_e;

  // Clock, reset and the two channels. Every input starts at a known value.
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic [2:0]        req_kind  = '0;
  logic [FileW-1:0]  req_file  = '0;
  logic [PageW-1:0]  req_page  = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic              rsp_hit;
  logic [FrameW-1:0] rsp_frame;
  logic              rsp_load;
  logic              rsp_wb;
  logic [FileW-1:0]  rsp_wb_file;
  logic [PageW-1:0]  rsp_wb_page;
  logic              rsp_status;
  logic              rsp_last;

  // Model of the frame pool. Ranks count up from 0 for the most recently used
  // frame; ranks of empty frames are never looked at.
  logic              pool_valid [NumFrames];
  logic              pool_dirty [NumFrames];
  logic [FileW-1:0]  pool_file  [NumFrames];
  logic [PageW-1:0]  pool_page  [NumFrames];
  int unsigned       pool_rank  [NumFrames];

  // Results the tracker still owes, oldest first.
  res_t              replies_due [$];
  res_t              reply_want;
  int                fail_count = 0;

  // Receiver stall pattern state.
  stall_style_e      stall_style = STALL_NONE;
  int                stall_left  = 0;
  int                block_left  = 0;
  logic              block_level = 1'b0;

  always #(ClkHalf) clk = ~clk;

  lru_page_buffer_tracker #(
    .NUM_FRAMES(NumFrames)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (req_valid),
    .in_stall_o      (req_stall),
    .kind_i          (req_kind),
    .file_id_i       (req_file),
    .page_number_i   (req_page),
    .out_valid_o     (rsp_valid),
    .out_stall_i     (rsp_stall),
    .hit_o           (rsp_hit),
    .frame_o         (rsp_frame),
    .load_needed_o   (rsp_load),
    .writeback_o     (rsp_wb),
    .wb_file_id_o    (rsp_wb_file),
    .wb_page_number_o(rsp_wb_page),
    .status_o        (rsp_status),
    .last_o          (rsp_last)
  );

  // --------------------------------------------------------------------------
  // Frame pool model
  // --------------------------------------------------------------------------

  // Appends one owed result at the back of the queue.
  function automatic void queue_reply(res_t r);
    replies_due = {replies_due, r};
  endfunction

  // Empties one frame and closes the gap it leaves in the recency order.
  function automatic void retire_frame(int slot);
    int i;
    for (i = 0; i < NumFrames; i++) begin
      if (pool_valid[i] && i != slot && pool_rank[i] > pool_rank[slot]) begin
        pool_rank[i]--;
      end
    end
    pool_valid[slot] = 1'b0;
    pool_dirty[slot] = 1'b0;
    pool_rank[slot]  = 0;
  endfunction

  // Applies one accepted request to the pool and queues the results it causes.
  function automatic void apply_pool_request(logic [2:0] kind, logic [FileW-1:0] fid,
                                             logic [PageW-1:0] pno);
    res_t        r;
    int          i;
    int          slot;
    int          dirty_hits;
    int          seen;
    int unsigned oldest;
    r      = '0;
    r.last = 1'b1;

    // A file flush writes back each dirty page of the file in frame order. Only
    // the final result carries last; with nothing to write there is one empty
    // result.
    if (kind == KIND_FLUSH_FILE) begin
      dirty_hits = 0;
      for (i = 0; i < NumFrames; i++) begin
        if (pool_valid[i] && pool_dirty[i] && pool_file[i] == fid) begin
          dirty_hits++;
        end
      end
      if (dirty_hits == 0) begin
        queue_reply(r);
        return;
      end
      seen = 0;
      for (i = 0; i < NumFrames; i++) begin
        if (pool_valid[i] && pool_dirty[i] && pool_file[i] == fid) begin
          seen++;
          r                = '0;
          r.hit            = 1'b1;
          r.frame          = FrameW'(i);
          r.writeback      = 1'b1;
          r.wb_file_id     = pool_file[i];
          r.wb_page_number = pool_page[i];
          r.last           = (seen == dirty_hits);
          pool_dirty[i]    = 1'b0;
          queue_reply(r);
        end
      end
      return;
    end

    if (kind > KIND_FLUSH_FILE) begin
      queue_reply(r);
      return;
    end

    slot = -1;
    for (i = 0; i < NumFrames; i++) begin
      if (slot < 0 && pool_valid[i] && pool_file[i] == fid && pool_page[i] == pno) begin
        slot = i;
      end
    end

    if (kind == KIND_GET) begin
      if (slot >= 0) begin
        // A hit moves the frame to the front of the recency order.
        for (i = 0; i < NumFrames; i++) begin
          if (pool_valid[i] && i != slot && pool_rank[i] < pool_rank[slot]) begin
            pool_rank[i]++;
          end
        end
        pool_rank[slot] = 0;
        r.hit   = 1'b1;
        r.frame = FrameW'(slot);
        queue_reply(r);
        return;
      end
      // A miss takes the lowest free frame, or else the least recently used
      // one, whose page is written back first when it is dirty.
      for (i = NumFrames - 1; i >= 0; i--) begin
        if (!pool_valid[i]) begin
          slot = i;
        end
      end
      if (slot < 0) begin
        oldest = 0;
        slot   = 0;
        for (i = 0; i < NumFrames; i++) begin
          if (pool_rank[i] >= oldest) begin
            oldest = pool_rank[i];
            slot   = i;
          end
        end
        if (pool_dirty[slot]) begin
          r.writeback      = 1'b1;
          r.wb_file_id     = pool_file[slot];
          r.wb_page_number = pool_page[slot];
        end
        retire_frame(slot);
      end
      for (i = 0; i < NumFrames; i++) begin
        if (pool_valid[i]) begin
          pool_rank[i]++;
        end
      end
      pool_valid[slot] = 1'b1;
      pool_dirty[slot] = 1'b0;
      pool_file[slot]  = fid;
      pool_page[slot]  = pno;
      pool_rank[slot]  = 0;
      r.frame          = FrameW'(slot);
      r.load_needed    = 1'b1;
      queue_reply(r);
      return;
    end

    // Mark_dirty, discard and flush_page on an absent page change nothing;
    // only mark_dirty reports it through status.
    if (slot < 0) begin
      if (kind == KIND_MARK_DIRTY) begin
        r.status = 1'b1;
      end
      queue_reply(r);
      return;
    end

    r.hit   = 1'b1;
    r.frame = FrameW'(slot);
    case (kind)
      KIND_MARK_DIRTY: begin
        pool_dirty[slot] = 1'b1;
      end
      KIND_DISCARD: begin
        // Freed without a writeback, even when dirty.
        retire_frame(slot);
      end
      default: begin
        if (pool_dirty[slot]) begin
          r.writeback      = 1'b1;
          r.wb_file_id     = pool_file[slot];
          r.wb_page_number = pool_page[slot];
          pool_dirty[slot] = 1'b0;
        end
      end
    endcase
    queue_reply(r);
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Presents one request at the falling edge and holds it until a rising edge
  // finds the tracker not stalling. Valid stays high on return, so that the
  // next call can follow back to back.
  task automatic send_request(logic [2:0] kind, logic [FileW-1:0] fid,
                              logic [PageW-1:0] pno);
    @(negedge clk);
    req_valid <= 1'b1;
    req_kind  <= kind;
    req_file  <= fid;
    req_page  <= pno;
    do begin
      @(posedge clk);
    end while (req_stall);
    apply_pool_request(kind, fid, pno);
  endtask

  // Leaves the request channel idle for the given number of cycles.
  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Stops sending and waits until every owed result has been taken.
  task automatic wait_pool_quiet();
    @(negedge clk);
    req_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // The stall pattern switches at random between styles: no stall at all,
  // sparse stalls, dense stalls, and long blocks of stall and release.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      stall_left  = $urandom_range(16, 160);
    end else begin
      stall_left--;
    end
    case (stall_style)
      STALL_NONE:  rsp_stall <= 1'b0;
      STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
      default: begin
        if (block_left == 0) begin
          block_level = ~block_level;
          block_left  = $urandom_range(1, 12);
        end else begin
          block_left--;
        end
        rsp_stall <= block_level;
      end
    endcase
  end

  task automatic compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Each result taken at a rising edge is checked against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && rsp_valid && !rsp_stall) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual frame %0h last %0b",
                 $time, rsp_frame, rsp_last);
        fail_count++;
      end else begin
        reply_want = replies_due.pop_front();
        compare_field("hit", 32'(reply_want.hit), 32'(rsp_hit));
        compare_field("frame", 32'(reply_want.frame), 32'(rsp_frame));
        compare_field("load_needed", 32'(reply_want.load_needed), 32'(rsp_load));
        compare_field("writeback", 32'(reply_want.writeback), 32'(rsp_wb));
        compare_field("wb_file_id", 32'(reply_want.wb_file_id), 32'(rsp_wb_file));
        compare_field("wb_page_number", 32'(reply_want.wb_page_number), 32'(rsp_wb_page));
        compare_field("status", 32'(reply_want.status), 32'(rsp_status));
        compare_field("last", 32'(reply_want.last), 32'(rsp_last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Requests on an empty pool: an absent page for mark_dirty and flush_page, a
  // file flush with nothing to write, and an unused kind with every bit set.
  task automatic test_empty_pool();
    send_request(KIND_MARK_DIRTY, 8'h00, 24'h000000);
    pause_sender($urandom_range(0, 4));
    send_request(KIND_FLUSH_PAGE, 8'hFF, 24'hFFFFFF);
    pause_sender($urandom_range(0, 4));
    send_request(KIND_FLUSH_FILE, 8'h00, 24'hFFFFFF);
    send_request(KindUnusedHi, 8'hFF, 24'hFFFFFF);
  endtask

  // Fills all frames, with both extremes of the tags among the pages, then
  // hits, dirties and flushes some of them, forces an eviction of a dirty
  // frame and discards one.
  task automatic test_fill_and_evict();
    int i;
    for (i = 0; i < NumFrames; i++) begin
      send_request(KIND_GET, i[0] ? 8'hFF : 8'h00,
                   (i == NumFrames - 1) ? 24'hFFFFFF : PageW'(i));
      pause_sender($urandom_range(0, 3));
    end
    // Frame 2 becomes most recent, which leaves frame 0 the oldest.
    send_request(KIND_GET, 8'h00, 24'h000002);
    send_request(KIND_MARK_DIRTY, 8'h00, 24'h000000);
    send_request(KIND_MARK_DIRTY, 8'hFF, 24'hFFFFFF);
    // A dirty page, then a clean one.
    send_request(KIND_FLUSH_PAGE, 8'hFF, 24'hFFFFFF);
    send_request(KIND_FLUSH_PAGE, 8'h00, 24'h000004);
    // The pool is full, so this miss evicts frame 0 with a writeback.
    send_request(KIND_GET, 8'h5A, 24'h123456);
    send_request(KIND_DISCARD, 8'hFF, 24'h000001);
  endtask

  // Mostly requests on a small working set of pages that overflows the pool,
  // so that hits, misses, evictions and multi-page file flushes all happen
  // often; now and then fully random tags to reach every bit.
  task automatic test_random_traffic();
    logic [FileW-1:0] file_pool [FilePoolSize];
    logic [PageW-1:0] page_pool [PagePoolSize];
    logic [2:0]       kind;
    logic [FileW-1:0] fid;
    logic [PageW-1:0] pno;
    int               i;
    int               sent;
    int               burst_left;
    int               roll;
    for (i = 0; i < FilePoolSize; i++) begin
      file_pool[i] = FileW'($urandom);
    end
    for (i = 0; i < PagePoolSize; i++) begin
      page_pool[i] = PageW'($urandom);
    end
    sent       = 0;
    burst_left = 0;
    while (sent < RandomRequests) begin
      // Halfway through, the sender holds off until the tracker has caught up.
      if (sent == RandomRequests / 2) begin
        wait_pool_quiet();
      end
      if (burst_left == 0) begin
        pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
      end
      burst_left--;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        kind = KIND_GET;
      end else if (roll < 65) begin
        kind = KIND_MARK_DIRTY;
      end else if (roll < 73) begin
        kind = KIND_DISCARD;
      end else if (roll < 85) begin
        kind = KIND_FLUSH_PAGE;
      end else if (roll < 97) begin
        kind = KIND_FLUSH_FILE;
      end else begin
        kind = 3'($urandom_range(KindUnusedLo, KindUnusedHi));
      end
      if ($urandom_range(0, 6) == 0) begin
        fid = FileW'($urandom);
        pno = PageW'($urandom);
      end else begin
        fid = file_pool[$urandom_range(0, FilePoolSize - 1)];
        pno = page_pool[$urandom_range(0, PagePoolSize - 1)];
      end
      send_request(kind, fid, pno);
      // Unused kinds only get an empty result and do not count.
      if (kind <= KIND_FLUSH_FILE) begin
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < NumFrames; i++) begin
      pool_valid[i] = 1'b0;
      pool_dirty[i] = 1'b0;
      pool_file[i]  = '0;
      pool_page[i]  = '0;
      pool_rank[i]  = 0;
    end
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_pool();
    wait_pool_quiet();
    test_fill_and_evict();
    wait_pool_quiet();
    test_random_traffic();
    wait_pool_quiet();

    // Any result arriving after the last one owed is caught by the checker.
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #4ms;
    $display("tb failed");
    $finish;
  end

endmodule

### sim.f
design/lpbt_pkg.sv
design/lpbt_tag_mem.sv
design/lpbt_rank_array.sv
design/lru_page_buffer_tracker.sv
tb/tb.sv
